/* rtl/core/mmp_pkg.sv */
// Shared constants and stage type for the p25519 radix-2^30 Montgomery multiplier.
package mmp_pkg;
	localparam int LIMB_W  = 30;
	localparam int N_LIMB  = 9;
	localparam int N_COL   = 2 * N_LIMB - 1;
	localparam int OPND_W  = 255;
	localparam int PP_W    = 2 * LIMB_W;
	localparam int COL_W   = 64;
	localparam int T_W     = 512;
	localparam int N_ROUND = 9;
	localparam int GRP_W   = LIMB_W * (N_COL - 1) + COL_W;

	localparam logic [LIMB_W-1:0] MONT_M = 30'd678152731;
	localparam logic [OPND_W-1:0] P_MOD  =
		255'h7FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFED;

	typedef struct packed {
		logic           vld;
		logic [T_W-1:0] t;
	} mmp_stage_t;
endpackage

/* rtl/core/mmp_mul.sv */
// Full product A*u: partial products, column sums, final carry-resolve add.
module mmp_mul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld,
	input  logic [mmp_pkg::OPND_W-1:0] a,
	input  logic [mmp_pkg::OPND_W-1:0] u,
	output mmp_pkg::mmp_stage_t       dout
);
	import mmp_pkg::*;

	localparam int EXT_W = LIMB_W * N_LIMB;

	logic [EXT_W-1:0] a_ext, u_ext;
	logic [PP_W-1:0]  pp_s1 [N_LIMB][N_LIMB];
	logic [COL_W-1:0] col_c [N_COL];
	logic [COL_W-1:0] col_s2 [N_COL];
	logic [GRP_W-1:0] grp_c [3];
	logic [GRP_W-1:0] sum_c;
	logic [T_W-1:0]   t_s3;
	logic vld_s1, vld_s2, vld_s3;

	assign a_ext = {(EXT_W - OPND_W)'(0), a};
	assign u_ext = {(EXT_W - OPND_W)'(0), u};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_LIMB; i++)
				for (int j = 0; j < N_LIMB; j++)
					pp_s1[i][j] <= a_ext[LIMB_W*i +: LIMB_W] * u_ext[LIMB_W*j +: LIMB_W];
		end
	end

	// at most nine 60-bit terms per column
	always_comb begin
		for (int k = 0; k < N_COL; k++)
			col_c[k] = '0;
		for (int i = 0; i < N_LIMB; i++)
			for (int j = 0; j < N_LIMB; j++)
				col_c[i+j] = col_c[i+j] + {(COL_W - PP_W)'(0), pp_s1[i][j]};
	end

	always_ff @(posedge clk) begin
		if (en)
			col_s2 <= col_c;
	end

	// columns three apart sit 90 bits apart, so each group packs without overlap
	always_comb begin
		for (int g = 0; g < 3; g++)
			grp_c[g] = '0;
		for (int k = 0; k < N_COL; k++)
			grp_c[k % 3][LIMB_W*k +: COL_W] = col_s2[k];
		sum_c = grp_c[0] + grp_c[1] + grp_c[2];
	end

	always_ff @(posedge clk) begin
		if (en)
			t_s3 <= sum_c[T_W-1:0];
	end

	assign dout.vld = vld_s3;
	assign dout.t   = t_s3;
endmodule

/* rtl/core/mmp_cell.sv */
// One reduction round: l from the low limb, then T = (T + l*p) / 2^30.
module mmp_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  mmp_pkg::mmp_stage_t din,
	output mmp_pkg::mmp_stage_t dout
);
	import mmp_pkg::*;

	logic [PP_W-1:0]   lm_c;
	logic [LIMB_W-1:0] l_s1;
	logic [T_W-1:0]    t_s1, t_s2;
	logic [LIMB_W+4:0] l19_c;
	logic [T_W-1:0]    sum_c;
	logic vld_s1, vld_s2;

	assign lm_c = din.t[LIMB_W-1:0] * MONT_M;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= din.vld;
			vld_s2 <= vld_s1;
		end
	end

	// l*p = l*2^255 - 19*l; the true sum is non-negative and below 2^512
	always_comb begin
		l19_c = {l_s1, 4'b0} + {2'b0, l_s1, 1'b0} + {5'b0, l_s1};
		sum_c = t_s1
			+ {(T_W - OPND_W - LIMB_W)'(0), l_s1, OPND_W'(0)}
			- {(T_W - LIMB_W - 5)'(0), l19_c};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1 <= lm_c[LIMB_W-1:0];
			t_s1 <= din.t;
			t_s2 <= {LIMB_W'(0), sum_c[T_W-1:LIMB_W]};
		end
	end

	assign dout.vld = vld_s2;
	assign dout.t   = t_s2;
endmodule

/* rtl/core/mmp_sub.sv */
// Final conditional subtraction of p and output register.
module mmp_sub (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  mmp_pkg::mmp_stage_t        din,
	output logic                       vld,
	output logic [mmp_pkg::OPND_W-1:0] prod
);
	import mmp_pkg::*;

	logic [OPND_W+1:0] d_c;
	logic              vld_q;
	logic [OPND_W-1:0] prod_q;

	// T < 2p here, so it fits in 256 bits
	assign d_c = {1'b0, din.t[OPND_W:0]} - {2'b0, P_MOD};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (en)
			vld_q <= din.vld;
	end

	always_ff @(posedge clk) begin
		if (en)
			prod_q <= d_c[OPND_W+1] ? din.t[OPND_W-1:0] : d_c[OPND_W-1:0];
	end

	assign vld  = vld_q;
	assign prod = prod_q;
endmodule

/* rtl/core/montgomery_mul_p25519_radix30.sv */
// Pipeline from input transfer to result: 3 product stages,
// two stages in each of nine round cells, one output register.
// Throughput: one product per cycle; the whole pipeline holds while a
// result waits under out_stall, set by the single output register.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
module montgomery_mul_p25519_radix30 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] a_word0,
	input  logic [63:0] a_word1,
	input  logic [63:0] a_word2,
	input  logic [62:0] a_word3,
	input  logic [63:0] u_word0,
	input  logic [63:0] u_word1,
	input  logic [63:0] u_word2,
	input  logic [62:0] u_word3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] prod_word0,
	output logic [63:0] prod_word1,
	output logic [63:0] prod_word2,
	output logic [62:0] prod_word3
);
	import mmp_pkg::*;

	logic              en;
	logic [OPND_W-1:0] prod;
	mmp_stage_t        chain [N_ROUND+1];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	mmp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (in_valid),
		.a      ({a_word3, a_word2, a_word1, a_word0}),
		.u      ({u_word3, u_word2, u_word1, u_word0}),
		.dout   (chain[0])
	);

	for (genvar r = 0; r < N_ROUND; r++) begin : g_round
		mmp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[r]),
			.dout   (chain[r+1])
		);
	end

	mmp_sub u_sub (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (chain[N_ROUND]),
		.vld    (out_valid),
		.prod   (prod)
	);

	assign prod_word0 = prod[63:0];
	assign prod_word1 = prod[127:64];
	assign prod_word2 = prod[191:128];
	assign prod_word3 = prod[254:192];
endmodule

/* rtl/core/mmp_checker.sv */
// Port-level checks for the Montgomery multiplier, bound to the top level.
module mmp_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] prod_word0,
	input logic [63:0] prod_word1,
	input logic [63:0] prod_word2,
	input logic [62:0] prod_word3
);
	import mmp_pkg::*;

	a_below_p: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({prod_word3, prod_word2, prod_word1, prod_word0} < P_MOD))
		else $error("result not reduced below p");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(prod_word0)
			&& $stable(prod_word3)))
		else $error("stalled result changed");
endmodule

bind montgomery_mul_p25519_radix30 mmp_props u_mmp_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.prod_word0 (prod_word0),
	.prod_word1 (prod_word1),
	.prod_word2 (prod_word2),
	.prod_word3 (prod_word3)
);
